FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ordered list store.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define OLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define OLS_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/olst_pkg.sv
// Shared types and constants for the ordered list store.
// Depends on nothing; imported by olst_cell and ordered_list_store.
`default_nettype none

package olst_pkg;

   // Fixed field widths of the transaction ports
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int WIDE_W   = 64;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET    = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

   // Per-cell update action, broadcast to the whole row
   typedef enum logic [1:0] {
      ACT_HOLD       = 2'd0,
      ACT_SHIFT_UP   = 2'd1,
      ACT_SHIFT_DOWN = 2'd2,
      ACT_WRITE      = 2'd3
   } act_type;

   typedef struct packed {
      act_type             act;
      logic [SLOT_W-1:0]   pos;
      logic [SLOT_W-1:0]   count;
      logic                load_match;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/olst_cell.sv
// One storage cell of the list row: holds one entry and its match flag.
// Depends on olst_pkg; instantiated in a row by ordered_list_store.
`default_nettype none

module olst_cell import olst_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] cmp_value,
   input  logic [DATA_WIDTH-1:0] wr_value,
   input  logic [DATA_WIDTH-1:0] left_word,
   input  logic [DATA_WIDTH-1:0] right_word,
   input  logic                  hit_in,
   output logic [DATA_WIDTH-1:0] word,
   output logic                  hit_out,
   output logic                  first,
   output logic [DATA_WIDTH-1:0] rd_word
);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  match_ff, match_in;
   logic                  at_pos;
   logic                  in_list;

   assign at_pos  = (INDEX == int'(ctrl.pos));
   assign in_list = (INDEX < int'(ctrl.count));

   always_comb begin
      match_in = match_ff;
      if (ctrl.load_match) begin
         match_in = in_list && (entry_ff == cmp_value);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.act)
         ACT_SHIFT_UP: begin
            if (INDEX > int'(ctrl.pos)) begin
               entry_in = left_word;
            end else if (at_pos) begin
               entry_in = wr_value;
            end
         end
         ACT_SHIFT_DOWN: begin
            // close the gap from the first match upward
            if (hit_out) begin
               entry_in = right_word;
            end
         end
         ACT_WRITE: begin
            if (at_pos) begin
               entry_in = wr_value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign word    = entry_ff;
   assign hit_out = hit_in | match_ff;
   assign first   = match_ff & ~hit_in;
   assign rd_word = at_pos ? entry_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/ordered_list_store.sv
// Top level of the ordered list store: control, result register and cell row.
// Depends on olst_pkg, olst_cell and assert_macros.svh.
//
//   channel | direction | handshake          | content
//   req_    | in        | req_valid/req_stall | kind, item_value, slot
//   rsp_    | out       | rsp_valid/rsp_stall | status, found_slot, read_value, flags
//   csr_    | in        | csr_valid/csr_ready | capacity_in_use
//
// A transaction first loads a match flag in every cell at the accept edge; then,
// once the result register is free, it commits any update in the cell row and fills that register.
// A new transaction is not accepted until the previous one has committed.
// Reset clears the fill count and sets capacity_in_use to 32; entries are not cleared.
// A stalled result waits in the output register; the next transaction is still accepted
// and holds before commit until that register frees.
`default_nettype none
`include "assert_macros.svh"

module ordered_list_store import olst_pkg::*; #(
   parameter int CAPACITY   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [VALUE_W-1:0]  req_item_value,
   input  logic [SLOT_W-1:0]          req_slot,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_found_slot,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [SLOT_W-1:0]          rsp_fill_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [SLOT_W-1:0]          csr_capacity_in_use
);

   localparam logic [SLOT_W-1:0] CAP_MAX =
      (CAPACITY > 63) ? 6'd63 : SLOT_W'(CAPACITY);
   localparam logic [SLOT_W-1:0] CAP_RESET = 6'd32;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic                  accept, commit;
   logic [SLOT_W-1:0]     capacity_ff, capacity_in, cap_eff;
   logic [SLOT_W-1:0]     count_ff, count_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [WIDE_W-1:0]     req_wide, rd_wide;
   logic [DATA_WIDTH-1:0] req_word, rd_sel;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, status_c;
   logic [SLOT_W-1:0]     rsp_found_ff, found_c;
   logic [VALUE_W-1:0]    rsp_read_ff, read_c;
   logic [SLOT_W-1:0]     rsp_fill_ff;
   logic                  rsp_empty_ff, rsp_full_ff;

   act_type               act_c;
   cell_ctrl_type         ctrl;

   logic [DATA_WIDTH-1:0] word_w  [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_w    [CAPACITY];
   logic [CAPACITY:0]     hit_w;
   logic [CAPACITY-1:0]   first_vec;
   logic                  any_hit;
   logic [SLOT_W-1:0]     first_pos;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign req_wide = WIDE_W'($unsigned(req_item_value));
   assign req_word = req_wide[DATA_WIDTH-1:0];

   // Configuration register
   assign csr_ready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_capacity_in_use;
      end
   end

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = 6'd1;
      end else if (capacity_ff > CAP_MAX) begin
         cap_eff = CAP_MAX;
      end else begin
         cap_eff = capacity_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Cell row
   assign hit_w[0] = 1'b0;
   assign any_hit  = hit_w[CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;

      if (i == 0) begin : g_left_edge
         assign left_w = value_ff;
      end else begin : g_left
         assign left_w = word_w[i-1];
      end

      if (i == CAPACITY-1) begin : g_right_edge
         assign right_w = word_w[i];
      end else begin : g_right
         assign right_w = word_w[i+1];
      end

      olst_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cmp_value  (req_word),
         .wr_value   (value_ff),
         .left_word  (left_w),
         .right_word (right_w),
         .hit_in     (hit_w[i]),
         .word       (word_w[i]),
         .hit_out    (hit_w[i+1]),
         .first      (first_vec[i]),
         .rd_word    (rd_w[i])
      );
   end

   always_comb begin
      rd_sel    = '0;
      first_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_sel = rd_sel | rd_w[i];
         if (first_vec[i]) begin
            first_pos = first_pos | SLOT_W'(i + 1);
         end
      end
   end

   assign rd_wide = WIDE_W'(rd_sel);

   // Operation decode in the execute cycle
   always_comb begin
      status_c = STAT_OK;
      found_c  = '0;
      read_c   = '0;
      act_c    = ACT_HOLD;
      count_in = count_ff;
      case (kind_ff)
         KIND_INSERT: begin
            if (count_ff >= cap_eff) begin
               status_c = STAT_FULL;
            end else if (slot_ff > count_ff) begin
               status_c = STAT_RANGE;
            end else begin
               act_c    = ACT_SHIFT_UP;
               count_in = count_ff + 6'd1;
            end
         end
         KIND_REMOVE: begin
            if (!any_hit) begin
               status_c = STAT_NOT_FOUND;
            end else begin
               act_c    = ACT_SHIFT_DOWN;
               count_in = count_ff - 6'd1;
            end
         end
         KIND_FIND: begin
            if (!any_hit) begin
               status_c = STAT_NOT_FOUND;
            end else begin
               found_c = first_pos;
            end
         end
         KIND_GET: begin
            if (slot_ff >= count_ff) begin
               status_c = STAT_RANGE;
            end else begin
               read_c = rd_wide[VALUE_W-1:0];
            end
         end
         KIND_SET: begin
            if (slot_ff == '0 || slot_ff > count_ff) begin
               status_c = STAT_RANGE;
            end else begin
               act_c = ACT_WRITE;
            end
         end
         default: begin
            status_c = STAT_OK;
         end
      endcase
      // drop everything until the result register can take it
      if (!commit) begin
         act_c    = ACT_HOLD;
         count_in = count_ff;
      end
   end

   always_comb begin
      ctrl.act        = act_c;
      ctrl.pos        = (kind_ff == KIND_SET) ? (slot_ff - 6'd1) : slot_ff;
      ctrl.count      = count_ff;
      ctrl.load_match = accept;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         slot_ff  <= req_slot;
         value_ff <= req_word;
      end
      if (commit) begin
         rsp_status_ff <= status_c;
         rsp_found_ff  <= found_c;
         rsp_read_ff   <= read_c;
         rsp_fill_ff   <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in >= cap_eff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_slot = rsp_found_ff;
   assign rsp_read_value = $signed(rsp_read_ff);
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;

   `OLS_ASSERT(a_count_bound, clock, reset, count_ff <= CAP_MAX, "fill count above capacity")
   `OLS_ASSERT(a_first_onehot, clock, reset, $onehot0(first_vec), "several first matches")
   `OLS_ASSERT(a_accept_exec, clock, reset, accept |=> (state_ff == ST_EXEC), "accept did not start execute")
   `OLS_ASSERT(a_commit_idle, clock, reset, commit |=> (rsp_valid_ff && state_ff == ST_IDLE), "commit did not post result")
   `OLS_ASSERT(a_err_keeps_count, clock, reset, (commit && status_c != STAT_OK) |=> $stable(count_ff), "failed op changed count")

endmodule

`default_nettype wire
